@@ src/dpfd_pkg.sv @@
// Shared types and constants for the PID controller with filtered derivative.
// Holds the item structs, the register block struct and the register and flag codes.
// Depends on nothing.
package dpfd_pkg;

    localparam int SAMPLE_W        = 16;
    localparam int ERR_W           = SAMPLE_W + 1;
    localparam int COEF_W          = 24;
    localparam int DEF_FRAC_BITS   = 16;
    localparam int PROD_W          = COEF_W + ERR_W;
    localparam int ACC_W           = PROD_W + 3;
    localparam int PADDR_W         = 5;
    localparam int PDATA_W         = 32;
    localparam int FLAG_W          = 2;

    localparam logic signed [SAMPLE_W-1:0] UPPER_RESET = SAMPLE_W'(255);
    localparam logic signed [SAMPLE_W-1:0] LOWER_RESET = '0;

    typedef enum logic [2:0] {
        REG_GAIN_ERR_NOW   = 3'd0,
        REG_GAIN_ERR_PREV1 = 3'd1,
        REG_GAIN_ERR_PREV2 = 3'd2,
        REG_GAIN_OUT_PREV1 = 3'd3,
        REG_GAIN_OUT_PREV2 = 3'd4,
        REG_UPPER_LIMIT    = 3'd5,
        REG_LOWER_LIMIT    = 3'd6
    } dpfd_reg_t;

    typedef enum logic [FLAG_W-1:0] {
        LIMIT_NONE  = 2'd0,
        LIMIT_UPPER = 2'd1,
        LIMIT_LOWER = 2'd2
    } dpfd_limit_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] measured;
        logic signed [SAMPLE_W-1:0] setpoint;
    } dpfd_in_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] drive;
        logic        [FLAG_W-1:0]   limit_hit;
    } dpfd_out_t;

    typedef struct packed {
        logic signed [COEF_W-1:0]   gain_err_now;
        logic signed [COEF_W-1:0]   gain_err_prev1;
        logic signed [COEF_W-1:0]   gain_err_prev2;
        logic signed [COEF_W-1:0]   gain_out_prev1;
        logic signed [COEF_W-1:0]   gain_out_prev2;
        logic signed [SAMPLE_W-1:0] upper_limit;
        logic signed [SAMPLE_W-1:0] lower_limit;
    } dpfd_cfg_t;

endpackage

@@ src/discrete_pid_filtered_derivative.sv @@
// Flow: an accepted sample waits in the sample register, then passes to the result
// register, raising result_valid. Throughput: one sample per cycle while not stalled;
// the clamped drive is registered and feeds the next sample's difference equation.
// Reset: asynchronous, active low; gains clear to zero, upper limit to 255,
// lower limit to zero, error and drive histories to zero, both stages empty.
module discrete_pid_filtered_derivative #(
    parameter int COEF_FRAC_BITS = dpfd_pkg::DEF_FRAC_BITS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         sample_valid,
    output logic                         sample_stall,
    input  dpfd_pkg::dpfd_in_t           sample,
    output logic                         result_valid,
    input  logic                         result_stall,
    output dpfd_pkg::dpfd_out_t          result,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [dpfd_pkg::PADDR_W-1:0] paddr,
    input  logic [dpfd_pkg::PDATA_W-1:0] pwdata,
    output logic [dpfd_pkg::PDATA_W-1:0] prdata,
    output logic                         pready
);
    import dpfd_pkg::*;

    dpfd_cfg_t cfg;

    dpfd_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    dpfd_core #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

@@ src/dpfd_regs.sv @@
// APB register block: five Q gains and the two clamp limits.
// Depends on dpfd_pkg.
module dpfd_regs (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [dpfd_pkg::PADDR_W-1:0] paddr,
    input  logic [dpfd_pkg::PDATA_W-1:0] pwdata,
    output logic [dpfd_pkg::PDATA_W-1:0] prdata,
    output logic                     pready,
    output dpfd_pkg::dpfd_cfg_t      cfg
);
    import dpfd_pkg::*;

    dpfd_cfg_t cfg_reg;
    dpfd_cfg_t cfg_next;
    dpfd_reg_t sel;
    logic      wr_en;

    assign sel    = dpfd_reg_t'(paddr[PADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (sel)
                REG_GAIN_ERR_NOW:   cfg_next.gain_err_now   = pwdata[COEF_W-1:0];
                REG_GAIN_ERR_PREV1: cfg_next.gain_err_prev1 = pwdata[COEF_W-1:0];
                REG_GAIN_ERR_PREV2: cfg_next.gain_err_prev2 = pwdata[COEF_W-1:0];
                REG_GAIN_OUT_PREV1: cfg_next.gain_out_prev1 = pwdata[COEF_W-1:0];
                REG_GAIN_OUT_PREV2: cfg_next.gain_out_prev2 = pwdata[COEF_W-1:0];
                REG_UPPER_LIMIT:    cfg_next.upper_limit    = pwdata[SAMPLE_W-1:0];
                REG_LOWER_LIMIT:    cfg_next.lower_limit    = pwdata[SAMPLE_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (sel)
            REG_GAIN_ERR_NOW:   prdata = PDATA_W'(cfg_reg.gain_err_now);
            REG_GAIN_ERR_PREV1: prdata = PDATA_W'(cfg_reg.gain_err_prev1);
            REG_GAIN_ERR_PREV2: prdata = PDATA_W'(cfg_reg.gain_err_prev2);
            REG_GAIN_OUT_PREV1: prdata = PDATA_W'(cfg_reg.gain_out_prev1);
            REG_GAIN_OUT_PREV2: prdata = PDATA_W'(cfg_reg.gain_out_prev2);
            REG_UPPER_LIMIT:    prdata = PDATA_W'(cfg_reg.upper_limit);
            REG_LOWER_LIMIT:    prdata = PDATA_W'(cfg_reg.lower_limit);
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_err_now   <= '0;
            cfg_reg.gain_err_prev1 <= '0;
            cfg_reg.gain_err_prev2 <= '0;
            cfg_reg.gain_out_prev1 <= '0;
            cfg_reg.gain_out_prev2 <= '0;
            cfg_reg.upper_limit    <= UPPER_RESET;
            cfg_reg.lower_limit    <= LOWER_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ src/dpfd_core.sv @@
// Sample register, difference equation with clamp, history and result register.
// Depends on dpfd_pkg.
module dpfd_core #(
    parameter int COEF_FRAC_BITS = dpfd_pkg::DEF_FRAC_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  dpfd_pkg::dpfd_cfg_t   cfg,
    input  logic                  sample_valid,
    output logic                  sample_stall,
    input  dpfd_pkg::dpfd_in_t    sample,
    output logic                  result_valid,
    input  logic                  result_stall,
    output dpfd_pkg::dpfd_out_t   result
);
    import dpfd_pkg::*;

    logic      smp_valid_reg;
    logic      smp_valid_next;
    dpfd_in_t  smp_reg;
    logic      res_valid_reg;
    logic      res_valid_next;
    dpfd_out_t res_reg;
    dpfd_out_t res_next;

    logic signed [ERR_W-1:0]    err_last_reg;
    logic signed [ERR_W-1:0]    err_blast_reg;
    logic signed [SAMPLE_W-1:0] drive_last_reg;
    logic signed [SAMPLE_W-1:0] drive_blast_reg;

    logic advance;
    logic fire;
    logic accept;

    logic signed [ERR_W-1:0]    err_now;
    logic signed [PROD_W-1:0]   prod0;
    logic signed [PROD_W-1:0]   prod1;
    logic signed [PROD_W-1:0]   prod2;
    logic signed [PROD_W-1:0]   prod3;
    logic signed [PROD_W-1:0]   prod4;
    logic signed [ACC_W-1:0]    acc;
    logic signed [ACC_W-1:0]    scaled;
    logic signed [ACC_W-1:0]    upper_ext;
    logic signed [ACC_W-1:0]    lower_ext;

    // The result register frees up when empty or being taken.
    assign advance      = !res_valid_reg || !result_stall;
    assign fire         = smp_valid_reg && advance;
    assign sample_stall = smp_valid_reg && !advance;
    assign accept       = sample_valid && !sample_stall;

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    assign err_now = ERR_W'(smp_reg.setpoint) - ERR_W'(smp_reg.measured);

    assign prod0 = cfg.gain_err_now   * err_now;
    assign prod1 = cfg.gain_err_prev1 * err_last_reg;
    assign prod2 = cfg.gain_err_prev2 * err_blast_reg;
    assign prod3 = cfg.gain_out_prev1 * drive_last_reg;
    assign prod4 = cfg.gain_out_prev2 * drive_blast_reg;

    assign acc = ACC_W'(prod0) + ACC_W'(prod1) + ACC_W'(prod2)
               + ACC_W'(prod3) + ACC_W'(prod4);
    assign scaled    = acc >>> COEF_FRAC_BITS;
    assign upper_ext = ACC_W'(cfg.upper_limit);
    assign lower_ext = ACC_W'(cfg.lower_limit);

    // Upper test wins when the limits cross.
    always_comb
    begin
        if (scaled > upper_ext)
        begin
            res_next.drive     = cfg.upper_limit;
            res_next.limit_hit = LIMIT_UPPER;
        end
        else if (scaled < lower_ext)
        begin
            res_next.drive     = cfg.lower_limit;
            res_next.limit_hit = LIMIT_LOWER;
        end
        else
        begin
            res_next.drive     = scaled[SAMPLE_W-1:0];
            res_next.limit_hit = LIMIT_NONE;
        end
    end

    always_comb
    begin
        smp_valid_next = smp_valid_reg;
        if (accept)
            smp_valid_next = 1'b1;
        else if (fire)
            smp_valid_next = 1'b0;

        res_valid_next = res_valid_reg;
        if (fire)
            res_valid_next = 1'b1;
        else if (!result_stall)
            res_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smp_valid_reg   <= 1'b0;
            res_valid_reg   <= 1'b0;
            err_last_reg    <= '0;
            err_blast_reg   <= '0;
            drive_last_reg  <= '0;
            drive_blast_reg <= '0;
        end
        else
        begin
            smp_valid_reg <= smp_valid_next;
            res_valid_reg <= res_valid_next;
            // Shift the histories with the clamped drive.
            if (fire)
            begin
                err_blast_reg   <= err_last_reg;
                err_last_reg    <= err_now;
                drive_blast_reg <= drive_last_reg;
                drive_last_reg  <= res_next.drive;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            smp_reg <= sample;
        if (fire)
            res_reg <= res_next;
    end

endmodule
